// ----- sv/cms_pkg.sv -----
`default_nettype none

package cms_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int OUT_W           = 32;
    localparam int HIST_LEN        = 12;
    localparam int QDEPTH          = 2;

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_GZIP  = 3'd0;
    localparam t_kind KIND_BZIP2 = 3'd1;
    localparam t_kind KIND_XZ    = 3'd2;
    localparam t_kind KIND_LZMA  = 3'd3;
    localparam t_kind KIND_NONE  = 3'd4;

    localparam logic [7:0] GZ_B0 = 8'h1F;
    localparam logic [7:0] GZ_B1 = 8'h8B;
    localparam logic [7:0] GZ_B2 = 8'h08;
    localparam logic [7:0] BZ_B0 = 8'h42;
    localparam logic [7:0] BZ_B1 = 8'h5A;
    localparam logic [7:0] BZ_B2 = 8'h68;
    localparam logic [7:0] XZ_B0 = 8'hFD;
    localparam logic [7:0] XZ_B1 = 8'h37;
    localparam logic [7:0] XZ_B2 = 8'h7A;
    localparam logic [7:0] XZ_B3 = 8'h58;
    localparam logic [7:0] XZ_B4 = 8'h5A;
    localparam logic [7:0] XZ_B5 = 8'h00;
    localparam logic [7:0] LZ_B0 = 8'h5D;
    localparam logic [7:0] LZ_PROP_LIM = 8'h20;

    typedef struct packed {
        logic             last;
        logic             hit_fixed;
        t_kind            kind;
        logic [OUT_W-1:0] off_fixed;
        logic             hit_lzma;
        logic [OUT_W-1:0] off_lzma;
    } t_cmd;

endpackage

`default_nettype wire

// ----- sv/cms_front.sv -----
`default_nettype none

module cms_front #(
    parameter int OFFSET_BITS = cms_pkg::OFFSET_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_stream_end,
    input  wire logic        i_q_full,
    output logic             o_in_stall,
    output logic             o_push,
    output cms_pkg::t_cmd    o_cmd
);

    localparam int OB    = OFFSET_BITS;
    localparam int EXT_W = (OB > cms_pkg::OUT_W) ? OB : cms_pkg::OUT_W;
    localparam int HL    = cms_pkg::HIST_LEN;

    logic [7:0]    r_hist [HL];
    logic [OB-1:0] r_pos;
    logic [OB-1:0] n_pos;

    logic          sat;
    logic          gz_hit, bz_hit, xz_hit, lz_hit;
    logic [OB-1:0] off3, off6, off13;

    function automatic logic [cms_pkg::OUT_W-1:0] clamp(input logic [OB-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (ext > EXT_W'({cms_pkg::OUT_W{1'b1}})) begin
            return {cms_pkg::OUT_W{1'b1}};
        end
        return ext[cms_pkg::OUT_W-1:0];
    endfunction

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    assign sat   = &r_pos;
    assign off3  = sat ? r_pos : r_pos - OB'(2);
    assign off6  = sat ? r_pos : r_pos - OB'(5);
    assign off13 = sat ? r_pos : r_pos - OB'(12);

    always_comb begin
        gz_hit = (r_pos >= OB'(2)) && r_hist[HL-2] == cms_pkg::GZ_B0
                 && r_hist[HL-1] == cms_pkg::GZ_B1 && i_data_byte == cms_pkg::GZ_B2;
        bz_hit = (r_pos >= OB'(2)) && r_hist[HL-2] == cms_pkg::BZ_B0
                 && r_hist[HL-1] == cms_pkg::BZ_B1 && i_data_byte == cms_pkg::BZ_B2;
        xz_hit = (r_pos >= OB'(5)) && r_hist[HL-5] == cms_pkg::XZ_B0
                 && r_hist[HL-4] == cms_pkg::XZ_B1 && r_hist[HL-3] == cms_pkg::XZ_B2
                 && r_hist[HL-2] == cms_pkg::XZ_B3 && r_hist[HL-1] == cms_pkg::XZ_B4
                 && i_data_byte == cms_pkg::XZ_B5;
        lz_hit = (r_pos >= OB'(12)) && r_hist[0] == cms_pkg::LZ_B0
                 && r_hist[4] < cms_pkg::LZ_PROP_LIM
                 && ((r_hist[10] == 8'h00 && r_hist[11] == 8'h00 && i_data_byte == 8'h00)
                     || (&{r_hist[5], r_hist[6], r_hist[7], r_hist[8], r_hist[9],
                           r_hist[10], r_hist[11], i_data_byte}));
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.last      = i_stream_end;
        o_cmd.hit_fixed = gz_hit || bz_hit || xz_hit;
        o_cmd.hit_lzma  = lz_hit;
        o_cmd.off_lzma  = clamp(off13);
        if (gz_hit) begin
            o_cmd.kind      = cms_pkg::KIND_GZIP;
            o_cmd.off_fixed = clamp(off3);
        end else if (bz_hit) begin
            o_cmd.kind      = cms_pkg::KIND_BZIP2;
            o_cmd.off_fixed = clamp(off3);
        end else begin
            o_cmd.kind      = cms_pkg::KIND_XZ;
            o_cmd.off_fixed = clamp(off6);
        end
    end

    always_comb begin
        if (i_stream_end) begin
            n_pos = '0;
        end else if (!sat) begin
            n_pos = r_pos + OB'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_push) begin
            r_pos <= n_pos;
        end
    end

    // history window, only read where position says its bytes are in the stream
    always_ff @(posedge i_clk) begin
        if (o_push) begin
            for (int i = 0; i < HL - 1; i++) begin
                r_hist[i] <= r_hist[i+1];
            end
            r_hist[HL-1] <= i_data_byte;
        end
    end

endmodule

`default_nettype wire

// ----- sv/cms_queue.sv -----
`default_nettype none

module cms_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire cms_pkg::t_cmd i_cmd,
    input  wire logic        i_pop,
    output logic             o_full,
    output logic             o_empty,
    output cms_pkg::t_cmd    o_cmd
);

    localparam int DEPTH = cms_pkg::QDEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cms_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= bump(r_wr);
            end
            if (do_pop) begin
                r_rd <= bump(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- sv/cms_back.sv -----
`default_nettype none

module cms_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_empty,
    input  wire cms_pkg::t_cmd              i_cmd,
    output logic                            o_pop,
    input  wire logic                       i_out_stall,
    output logic                            o_out_valid,
    output cms_pkg::t_kind                  o_kind,
    output logic [cms_pkg::OUT_W-1:0]       o_start_offset
);

    logic                        r_reported, n_reported;
    logic                        r_seen, n_seen;
    logic [cms_pkg::OUT_W-1:0]   r_lpos, n_lpos;
    logic                        r_out_valid;
    cms_pkg::t_kind              r_kind, n_kind;
    logic [cms_pkg::OUT_W-1:0]   r_off, n_off;
    logic                        emit;

    assign o_pop          = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_start_offset = r_off;

    always_comb begin
        n_reported = r_reported;
        n_seen     = r_seen;
        n_lpos     = r_lpos;
        emit       = 1'b0;
        n_kind     = cms_pkg::KIND_NONE;
        n_off      = '0;
        if (r_reported) begin
            if (i_cmd.last) begin
                n_reported = 1'b0;
                n_seen     = 1'b0;
                n_lpos     = '0;
            end
        end else if (i_cmd.hit_fixed) begin
            emit       = 1'b1;
            n_kind     = i_cmd.kind;
            n_off      = i_cmd.off_fixed;
            n_reported = !i_cmd.last;
            if (i_cmd.last) begin
                n_seen = 1'b0;
                n_lpos = '0;
            end
        end else begin
            if (!r_seen && i_cmd.hit_lzma) begin
                n_seen = 1'b1;
                n_lpos = i_cmd.off_lzma;
            end
            if (i_cmd.last) begin
                emit = 1'b1;
                if (n_seen) begin
                    n_kind = cms_pkg::KIND_LZMA;
                    n_off  = n_lpos;
                end
                n_seen = 1'b0;
                n_lpos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reported  <= 1'b0;
            r_seen      <= 1'b0;
            r_lpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_reported <= n_reported;
                r_seen     <= n_seen;
                r_lpos     <= n_lpos;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_kind <= n_kind;
            r_off  <= n_off;
        end
    end

endmodule

`default_nettype wire

// ----- sv/compression_magic_scanner_core.sv -----
// channel | valid      | stall        | beat fields
// --------+------------+--------------+------------------------------
// in      | i_in_valid | o_in_stall   | i_data_byte, i_stream_end
// out     | o_out_valid| i_out_stall  | o_kind, o_start_offset
//
// one beat per cycle sustained while the output does not stall; a result passes
// through the two-entry command queue and then the output register.
// o_in_stall is high only while the queue is full; a result held by a stalled output
// blocks the back end, so the input stalls once the queue has filled.
// reset is synchronous, active low, and clears position, flags and the queue.
`default_nettype none

module compression_magic_scanner_core #(
    parameter int OFFSET_BITS = cms_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [7:0]                i_data_byte,
    input  wire logic                      i_stream_end,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [2:0]                     o_kind,
    output logic [cms_pkg::OUT_W-1:0]      o_start_offset
);

    cms_pkg::t_cmd front_cmd;
    cms_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    cms_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .i_stream_end(i_stream_end),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    cms_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (front_cmd),
        .i_pop  (pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_cmd  (head_cmd)
    );

    cms_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_start_offset(o_start_offset)
    );

endmodule

`default_nettype wire

// ----- sv/cms_checker.sv -----
`default_nettype none

module cms_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      o_in_stall,
    input wire logic [7:0]                i_data_byte,
    input wire logic                      i_stream_end,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic [2:0]                o_kind,
    input wire logic [cms_pkg::OUT_W-1:0] o_start_offset
);

    // held result beat does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
                                       && $stable(o_start_offset))
        else $error("output beat changed under stall");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == cms_pkg::KIND_NONE |-> o_start_offset == '0)
        else $error("not-found result with nonzero offset");

    // input side can only fill up after taking a beat
    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stall rose without an accepted beat");

    // a fresh result needs some accepted beat before it
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && !$past(o_in_stall) && !$past(i_in_valid, 1)
        && !$past(i_in_valid, 2) && !$past(o_in_stall, 2) && !$past(o_out_valid, 2)
        && !$past(o_in_stall, 3) && !$past(i_in_valid, 3) && !$past(o_out_valid, 3)
        |-> 1'b0)
        else $error("result beat without a cause");

endmodule

bind compression_magic_scanner_core cms_checker u_cms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_data_byte   (i_data_byte),
    .i_stream_end  (i_stream_end),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kind        (o_kind),
    .o_start_offset(o_start_offset)
);

`default_nettype wire
